/* rtl/core/pvt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pvt_pkg;

    // Command codes
    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_SMART  = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_MOVE   = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;
    localparam logic [2:0] CMD_READ   = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    // Command word
    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic [23:0]        color_in;
        logic [8:0]         slot;
        logic [15:0]        radius;
    } request_t;

    // Result word
    typedef struct packed {
        logic [1:0]         status;
        logic [8:0]         vertex_count;
        logic [7:0]         position;
        logic signed [15:0] read_x;
        logic signed [15:0] read_y;
        logic signed [15:0] read_z;
        logic [23:0]        read_color;
    } response_t;

    // Controls of the shared square-and-accumulate unit
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clear;
    } mac_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/pvt_store.sv */
`timescale 1ns / 1ps
`default_nettype none

// Vertex table storage: one write port, one read port with registered data
module pvt_store #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 72
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/pvt_mac.sv */
`timescale 1ns / 1ps
`default_nettype none

// Shared unit: difference, square, then accumulate over the three axes
module pvt_mac
    import pvt_pkg::*;
#(
    parameter int CW = 17
) (
    input  wire logic                 clk,
    input  wire mac_ctrl_t            ctrl,
    input  wire logic signed [CW-1:0] op_a,
    input  wire logic signed [CW-1:0] op_b,
    output logic         [2*CW-1:0]   prod,
    output logic         [2*CW+1:0]   acc
);

    localparam int PW = 2 * CW;
    localparam int AC = PW + 2;

    logic signed [CW-1:0] diff;
    logic signed [PW-1:0] square;
    logic [PW-1:0]        prod_reg;
    logic [AC-1:0]        acc_reg;
    logic [AC-1:0]        acc_next;

    // Operands stay in range, so the difference fits CW bits
    assign diff   = op_a - op_b;
    assign square = diff * diff;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_en)
        begin
            acc_next = (ctrl.acc_clear ? '0 : acc_reg) + AC'(prod_reg);
        end
    end

    // Product register, then accumulator
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= square;
        end
        acc_reg <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

/* rtl/core/polyline_vertex_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake             Word
// command    in         start high, busy low  request  (pvt_pkg::request_t)
// result     out        done strobe, 1 cycle  response (pvt_pkg::response_t)
//
// Sequence: read, clear and failed commands go straight to fetch and result;
// append and insert shift up the entries at or above the new position first; move
// rewrites one entry. Smart insert and delete walk the table through the one
// shared square-accumulate unit, states MX, MY, MZ, AZ and CMP per vertex, then
// shift the entries at 1 per cycle over the memory's one read and one write port.
// Reset clears the vertex count, state and done; table contents are never cleared.
// The receiver cannot stall: done flags each result for one cycle only.

module polyline_vertex_table_unit
    import pvt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int COORD_BITS  = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire request_t  request,
    output logic           busy,
    output logic           done,
    output response_t      response
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CNT1   = CNT_W + 1;
    localparam int SW     = (CNT_W > 9) ? CNT_W : 9;
    localparam int CB     = COORD_BITS;
    localparam int CW     = ((CB > 16) ? CB : 16) + 1;
    localparam int PW     = 2 * CW;
    localparam int AC     = PW + 2;
    localparam int WW     = 3 * CB + 24;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic signed [CW-1:0] C_HI = CW'((1 << (CB - 1)) - 1);
    localparam logic signed [CW-1:0] C_LO = -C_HI - CW'(1);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MX    = 4'd1;
    localparam logic [3:0] S_MY    = 4'd2;
    localparam logic [3:0] S_MZ    = 4'd3;
    localparam logic [3:0] S_AZ    = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_R2A   = 4'd6;
    localparam logic [3:0] S_SEL   = 4'd7;
    localparam logic [3:0] S_INS   = 4'd8;
    localparam logic [3:0] S_SHU   = 4'd9;
    localparam logic [3:0] S_WNEW  = 4'd10;
    localparam logic [3:0] S_SHD   = 4'd11;
    localparam logic [3:0] S_DEC   = 4'd12;
    localparam logic [3:0] S_MVWR  = 4'd13;
    localparam logic [3:0] S_FETCH = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    // Saturate to the stored coordinate range
    function automatic logic signed [CB-1:0] clamp_c(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        begin
            if (v > C_HI)
            begin
                r = C_HI;
            end
            else if (v < C_LO)
            begin
                r = C_LO;
            end
            else
            begin
                r = v;
            end
            clamp_c = r[CB-1:0];
        end
    endfunction

    logic [3:0]       state_reg,  state_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             done_reg,   done_next;
    request_t         req_reg,    req_next;
    logic [CNT_W-1:0] idx_reg,    idx_next;
    logic [CNT_W-1:0] pos_reg,    pos_next;
    logic [1:0]       status_reg, status_next;
    logic             show_reg,   show_next;
    logic [AC-1:0]    d1_reg,     d1_next;
    logic [AC-1:0]    d2_reg,     d2_next;
    logic [CNT_W-1:0] n1_reg,     n1_next;
    logic [CNT_W-1:0] n2_reg,     n2_next;
    logic [AC-1:0]    r2_reg,     r2_next;
    response_t        result_reg, result_next;

    // Memory ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WW-1:0]     wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WW-1:0]     rd_data;

    // Shared unit
    mac_ctrl_t            mac_ctrl;
    logic signed [CW-1:0] mac_a;
    logic signed [CW-1:0] mac_b;
    logic [PW-1:0]        mac_prod;
    logic [AC-1:0]        mac_acc;

    // Fields of the entry read back
    logic signed [CB-1:0] rd_x, rd_y, rd_z;
    logic [23:0]          rd_color;

    logic [SW-1:0]   slot_ext;
    logic [SW-1:0]   cnt_ext;
    logic            idx_more;
    logic            idx_more2;
    logic            pos_valid;

    assign rd_x     = rd_data[WW-1 -: CB];
    assign rd_y     = rd_data[WW-CB-1 -: CB];
    assign rd_z     = rd_data[WW-2*CB-1 -: CB];
    assign rd_color = rd_data[23:0];

    assign slot_ext  = SW'(request.slot);
    assign cnt_ext   = SW'(count_reg);
    assign idx_more  = (CNT1'(idx_reg) + CNT1'(1)) < CNT1'(count_reg);
    assign idx_more2 = (CNT1'(idx_reg) + CNT1'(2)) < CNT1'(count_reg);
    assign pos_valid = show_reg && (pos_reg < count_reg);

    pvt_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (WW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pvt_mac #(
        .CW (CW)
    ) u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        req_next    = req_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        show_next   = show_reg;
        d1_next     = d1_reg;
        d2_next     = d2_reg;
        n1_next     = n1_reg;
        n2_next     = n2_reg;
        r2_next     = r2_reg;
        result_next = result_reg;

        wr_en    = 1'b0;
        wr_addr  = pos_reg[ADDR_W-1:0];
        wr_data  = rd_data;
        rd_en    = 1'b0;
        rd_addr  = idx_reg[ADDR_W-1:0];

        mac_ctrl = '0;
        mac_a    = CW'(req_reg.coord_x);
        mac_b    = CW'(rd_x);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = request;
                    status_next = ST_OK;
                    show_next   = 1'b0;
                    pos_next    = '0;
                    state_next  = S_FETCH;
                    case (request.command)
                        CMD_APPEND, CMD_INSERT, CMD_SMART:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (request.command == CMD_INSERT && slot_ext > cnt_ext)
                            begin
                                status_next = ST_BAD_SLOT;
                            end
                            else if (request.command == CMD_INSERT)
                            begin
                                pos_next   = slot_ext[CNT_W-1:0];
                                state_next = S_INS;
                            end
                            else if (request.command == CMD_SMART && count_reg > CNT_W'(1))
                            begin
                                d1_next    = '1;
                                d2_next    = '1;
                                idx_next   = '0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_MX;
                            end
                            else
                            begin
                                pos_next   = count_reg;
                                state_next = S_INS;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NONE;
                            end
                            else
                            begin
                                // radius squared through the shared unit
                                mac_ctrl.mul_en = 1'b1;
                                mac_a      = $signed(CW'({1'b0, request.radius}));
                                mac_b      = '0;
                                idx_next   = '0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_R2A;
                            end
                        end
                        CMD_MOVE:
                        begin
                            if (slot_ext >= cnt_ext)
                            begin
                                status_next = ST_BAD_SLOT;
                            end
                            else
                            begin
                                pos_next   = slot_ext[CNT_W-1:0];
                                rd_en      = 1'b1;
                                rd_addr    = slot_ext[ADDR_W-1:0];
                                state_next = S_MVWR;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_READ:
                        begin
                            if (slot_ext >= cnt_ext)
                            begin
                                status_next = ST_BAD_SLOT;
                            end
                            else
                            begin
                                pos_next  = slot_ext[CNT_W-1:0];
                                show_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_R2A:
            begin
                r2_next    = AC'(mac_prod);
                state_next = S_MX;
            end

            // Distance of entry idx: one axis per cycle
            S_MX:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_a      = CW'(req_reg.coord_x);
                mac_b      = CW'(rd_x);
                state_next = S_MY;
            end

            S_MY:
            begin
                mac_ctrl.mul_en    = 1'b1;
                mac_ctrl.acc_en    = 1'b1;
                mac_ctrl.acc_clear = 1'b1;
                mac_a      = CW'(req_reg.coord_y);
                mac_b      = CW'(rd_y);
                state_next = S_MZ;
            end

            S_MZ:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_en = 1'b1;
                mac_a      = CW'(req_reg.coord_z);
                mac_b      = CW'(rd_z);
                state_next = S_AZ;
            end

            S_AZ:
            begin
                mac_ctrl.acc_en = 1'b1;
                state_next      = S_CMP;
            end

            S_CMP:
            begin
                if (req_reg.command == CMD_SMART)
                begin
                    // keep two nearest; lower index wins ties
                    if (mac_acc < d1_reg)
                    begin
                        d2_next = d1_reg;
                        n2_next = n1_reg;
                        d1_next = mac_acc;
                        n1_next = idx_reg;
                    end
                    else if (mac_acc < d2_reg)
                    begin
                        d2_next = mac_acc;
                        n2_next = idx_reg;
                    end
                    if (idx_more)
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        rd_en      = 1'b1;
                        rd_addr    = idx_next[ADDR_W-1:0];
                        state_next = S_MX;
                    end
                    else
                    begin
                        state_next = S_SEL;
                    end
                end
                else
                begin
                    if (mac_acc < r2_reg)
                    begin
                        pos_next = idx_reg;
                        if (idx_more)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = idx_reg[ADDR_W-1:0] + ADDR_W'(1);
                            state_next = S_SHD;
                        end
                        else
                        begin
                            state_next = S_DEC;
                        end
                    end
                    else if (idx_more)
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        rd_en      = 1'b1;
                        rd_addr    = idx_next[ADDR_W-1:0];
                        state_next = S_MX;
                    end
                    else
                    begin
                        status_next = ST_NONE;
                        state_next  = S_FETCH;
                    end
                end
            end

            S_SEL:
            begin
                pos_next   = ((n1_reg < n2_reg) ? n1_reg : n2_reg) + CNT_W'(1);
                state_next = S_INS;
            end

            S_INS:
            begin
                if (count_reg > pos_reg)
                begin
                    idx_next   = count_reg - CNT_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = idx_next[ADDR_W-1:0];
                    state_next = S_SHU;
                end
                else
                begin
                    state_next = S_WNEW;
                end
            end

            // Shift up: entry idx moves to idx + 1
            S_SHU:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[ADDR_W-1:0] + ADDR_W'(1);
                wr_data = rd_data;
                if (idx_reg > pos_reg)
                begin
                    idx_next = idx_reg - CNT_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_next[ADDR_W-1:0];
                end
                else
                begin
                    state_next = S_WNEW;
                end
            end

            S_WNEW:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[ADDR_W-1:0];
                wr_data    = {clamp_c(CW'(req_reg.coord_x)),
                              clamp_c(CW'(req_reg.coord_y)),
                              clamp_c(CW'(req_reg.coord_z)),
                              req_reg.color_in};
                count_next = count_reg + CNT_W'(1);
                show_next  = 1'b1;
                state_next = S_FETCH;
            end

            // Shift down: entry idx + 1 moves to idx
            S_SHD:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[ADDR_W-1:0];
                wr_data = rd_data;
                if (idx_more2)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg[ADDR_W-1:0] + ADDR_W'(2);
                end
                else
                begin
                    state_next = S_DEC;
                end
            end

            S_DEC:
            begin
                count_next = count_reg - CNT_W'(1);
                show_next  = 1'b1;
                state_next = S_FETCH;
            end

            S_MVWR:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[ADDR_W-1:0];
                wr_data    = {clamp_c(CW'(rd_x) + CW'(req_reg.coord_x)),
                              clamp_c(CW'(rd_y) + CW'(req_reg.coord_y)),
                              clamp_c(CW'(rd_z) + CW'(req_reg.coord_z)),
                              rd_color};
                show_next  = 1'b1;
                state_next = S_FETCH;
            end

            S_FETCH:
            begin
                rd_en      = pos_valid;
                rd_addr    = pos_reg[ADDR_W-1:0];
                state_next = S_OUT;
            end

            S_OUT:
            begin
                result_next.status       = status_reg;
                result_next.vertex_count = 9'(count_reg);
                result_next.position     = 8'(pos_reg);
                if (pos_valid)
                begin
                    result_next.read_x     = 16'(rd_x);
                    result_next.read_y     = 16'(rd_y);
                    result_next.read_z     = 16'(rd_z);
                    result_next.read_color = rd_color;
                end
                else
                begin
                    result_next.read_x     = '0;
                    result_next.read_y     = '0;
                    result_next.read_z     = '0;
                    result_next.read_color = '0;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        show_reg   <= show_next;
        d1_reg     <= d1_next;
        d2_reg     <= d2_next;
        n1_reg     <= n1_next;
        n2_reg     <= n2_next;
        r2_reg     <= r2_next;
        result_reg <= result_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign response = result_reg;

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequencer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("vertex count above table depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.status == ST_FULL) |-> (count_reg == FULL_CNT))
        else $error("table full reported with free entries");

endmodule

`default_nettype wire

/* bench/polyline_vertex_table_unit_tb.sv */
`timescale 1ns / 1ps

module polyline_vertex_table_unit_tb;
    import pvt_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 1600;
    localparam int RANDOM_PER_PHASE = 86;
    localparam int EXP_DEPTH   = 256;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // One directed row: command word, and a typed-in result where it is obvious
    typedef struct packed {
        request_t  req;
        logic      has_rsp;
        response_t rsp;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    request_t  request;
    logic      busy;
    logic      done;
    response_t response;

    // Shadow copy of the vertex table
    logic signed [15:0] tbl_x [TABLE_DEPTH];
    logic signed [15:0] tbl_y [TABLE_DEPTH];
    logic signed [15:0] tbl_z [TABLE_DEPTH];
    logic [23:0]        tbl_color [TABLE_DEPTH];
    int                 tbl_count;

    // Expected result words, oldest at exp_rd
    response_t expected_results [EXP_DEPTH];
    int        exp_wr;
    int        exp_rd;
    int        mismatch_count;
    int        idle_cycles;

    polyline_vertex_table_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (16)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .response (response)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic request_t mk_req(logic [2:0] cmd, int x, int y, int z, int col,
                                        int slot, int rad);
        request_t r;
        r.command  = cmd;
        r.coord_x  = x[15:0];
        r.coord_y  = y[15:0];
        r.coord_z  = z[15:0];
        r.color_in = col[23:0];
        r.slot     = slot[8:0];
        r.radius   = rad[15:0];
        return r;
    endfunction

    function automatic response_t mk_rsp(logic [1:0] st, int cnt, int pos, int x, int y,
                                         int z, int col);
        response_t r;
        r.status       = st;
        r.vertex_count = cnt[8:0];
        r.position     = pos[7:0];
        r.read_x       = x[15:0];
        r.read_y       = y[15:0];
        r.read_z       = z[15:0];
        r.read_color   = col[23:0];
        return r;
    endfunction

    // Squared distance from a stored vertex to a point, exact
    function automatic longint unsigned sq_dist(int idx, logic signed [15:0] x,
                                                logic signed [15:0] y, logic signed [15:0] z);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(x) - longint'(tbl_x[idx]);
        dy = longint'(y) - longint'(tbl_y[idx]);
        dz = longint'(z) - longint'(tbl_z[idx]);
        return unsigned'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Apply one command to the shadow table and return the result word it gives
    function automatic response_t predict_vertex_op(request_t rq);
        response_t        rs;
        int               at;
        int               pos;
        int               i;
        int               near1;
        int               near2;
        int               tmp_i;
        longint unsigned  d;
        longint unsigned  d1;
        longint unsigned  d2;
        longint unsigned  r2;
        logic             show;
        logic             found;
        rs    = '0;
        pos   = 0;
        show  = 1'b0;
        found = 1'b0;
        case (rq.command)
            CMD_APPEND, CMD_INSERT, CMD_SMART:
            begin
                if (tbl_count >= TABLE_DEPTH)
                    rs.status = ST_FULL;
                else if (rq.command == CMD_INSERT && int'(rq.slot) > tbl_count)
                    rs.status = ST_BAD_SLOT;
                else
                begin
                    at = tbl_count;
                    if (rq.command == CMD_INSERT)
                        at = int'(rq.slot);
                    else if (rq.command == CMD_SMART && tbl_count > 1)
                    begin
                        // two nearest, lower index wins ties
                        near1 = 0;
                        near2 = 1;
                        d1 = sq_dist(0, rq.coord_x, rq.coord_y, rq.coord_z);
                        d2 = sq_dist(1, rq.coord_x, rq.coord_y, rq.coord_z);
                        if (d2 < d1)
                        begin
                            d = d1; d1 = d2; d2 = d;
                            near1 = 1; near2 = 0;
                        end
                        for (i = 2; i < tbl_count; i++)
                        begin
                            d = sq_dist(i, rq.coord_x, rq.coord_y, rq.coord_z);
                            if (d < d1)
                            begin
                                d2 = d1; near2 = near1;
                                d1 = d; near1 = i;
                            end
                            else if (d < d2)
                            begin
                                d2 = d; near2 = i;
                            end
                        end
                        tmp_i = (near1 < near2) ? near1 : near2;
                        at = tmp_i + 1;
                    end
                    for (i = tbl_count; i > at; i--)
                    begin
                        tbl_x[i]     = tbl_x[i - 1];
                        tbl_y[i]     = tbl_y[i - 1];
                        tbl_z[i]     = tbl_z[i - 1];
                        tbl_color[i] = tbl_color[i - 1];
                    end
                    tbl_x[at]     = rq.coord_x;
                    tbl_y[at]     = rq.coord_y;
                    tbl_z[at]     = rq.coord_z;
                    tbl_color[at] = rq.color_in;
                    tbl_count++;
                    pos  = at;
                    show = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                r2 = 64'(rq.radius) * 64'(rq.radius);
                rs.status = ST_NONE;
                for (i = 0; i < tbl_count && !found; i++)
                begin
                    if (sq_dist(i, rq.coord_x, rq.coord_y, rq.coord_z) < r2)
                    begin
                        found = 1'b1;
                        pos   = i;
                    end
                end
                if (found)
                begin
                    // close the gap, color goes with the vertex
                    for (i = pos; i + 1 < tbl_count; i++)
                    begin
                        tbl_x[i]     = tbl_x[i + 1];
                        tbl_y[i]     = tbl_y[i + 1];
                        tbl_z[i]     = tbl_z[i + 1];
                        tbl_color[i] = tbl_color[i + 1];
                    end
                    tbl_count--;
                    rs.status = ST_OK;
                    show = 1'b1;
                end
            end
            CMD_MOVE:
            begin
                if (int'(rq.slot) >= tbl_count)
                    rs.status = ST_BAD_SLOT;
                else
                begin
                    pos = int'(rq.slot);
                    tbl_x[pos] = sat16(longint'(tbl_x[pos]) + longint'(rq.coord_x));
                    tbl_y[pos] = sat16(longint'(tbl_y[pos]) + longint'(rq.coord_y));
                    tbl_z[pos] = sat16(longint'(tbl_z[pos]) + longint'(rq.coord_z));
                    show = 1'b1;
                end
            end
            CMD_CLEAR:
                tbl_count = 0;
            CMD_READ:
            begin
                if (int'(rq.slot) >= tbl_count)
                    rs.status = ST_BAD_SLOT;
                else
                begin
                    pos  = int'(rq.slot);
                    show = 1'b1;
                end
            end
            default:
                ;
        endcase
        rs.vertex_count = tbl_count[8:0];
        rs.position     = pos[7:0];
        if (show && pos < tbl_count)
        begin
            rs.read_x     = tbl_x[pos];
            rs.read_y     = tbl_y[pos];
            rs.read_z     = tbl_z[pos];
            rs.read_color = tbl_color[pos];
        end
        return rs;
    endfunction

    // Coordinate: small cluster (ties, near hits), full range, or an extreme
    function automatic logic signed [15:0] random_coord(int mode);
        logic signed [15:0] c;
        int                 sel;
        case (mode)
            0, 1:
            begin
                sel = $urandom_range(16);
                c = 16'(sel - 8);
            end
            2:
                c = 16'($urandom());
            default:
            begin
                sel = $urandom_range(3);
                case (sel)
                    0: c = 16'sh7FFF;
                    1: c = 16'sh8000;
                    2: c = 16'sh0000;
                    default: c = 16'shFFFF;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int       pick;
        int       mode;
        pick = $urandom_range(99);
        if (pick < 14)
            rq.command = CMD_APPEND;
        else if (pick < 28)
            rq.command = CMD_INSERT;
        else if (pick < 48)
            rq.command = CMD_SMART;
        else if (pick < 64)
            rq.command = CMD_DELETE;
        else if (pick < 76)
            rq.command = CMD_MOVE;
        else if (pick < 92)
            rq.command = CMD_READ;
        else if (pick < 97)
            rq.command = CMD_CLEAR;
        else
            rq.command = CMD_UNUSED;
        // keep the table short so walks stay cheap
        if (tbl_count > 40 && $urandom_range(9) == 0)
            rq.command = CMD_CLEAR;
        mode = $urandom_range(3);
        rq.coord_x  = random_coord(mode);
        rq.coord_y  = random_coord(mode);
        rq.coord_z  = random_coord(mode);
        rq.color_in = 24'($urandom());
        if ($urandom_range(9) == 0)
            rq.slot = 9'($urandom());
        else
            rq.slot = 9'($urandom_range(tbl_count));
        if ($urandom_range(3) == 0)
            rq.radius = 16'($urandom());
        else
            rq.radius = 16'($urandom_range(12));
        return rq;
    endfunction

    // Present one word, wait for it to be taken, then log what it should give
    task automatic issue(input request_t rq, input logic has_rsp, input response_t rsp);
        response_t predicted;
        @(negedge clk);
        start   <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_vertex_op(rq);
        expected_results[exp_wr % EXP_DEPTH] = has_rsp ? rsp : predicted;
        exp_wr++;
    endtask

    // Drop start and hold off until every result is back
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_results
        response_t want;
        if (rst_n && done)
        begin
            if (exp_wr == exp_rd)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: st=%0d cnt=%0d pos=%0d", response.status,
                             response.vertex_count, response.position);
            end
            else
            begin
                want = expected_results[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (response.status !== want.status
                    || response.vertex_count !== want.vertex_count
                    || response.position !== want.position
                    || response.read_x !== want.read_x
                    || response.read_y !== want.read_y
                    || response.read_z !== want.read_z
                    || response.read_color !== want.read_color)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result mismatch at %0t: exp st=%0d cnt=%0d pos=%0d %s",
                                 $realtime, want.status, want.vertex_count, want.position,
                                 "(expected, then actual)");
                        $display("  exp x=%0d y=%0d z=%0d col=%06h",
                                 $signed(want.read_x), $signed(want.read_y),
                                 $signed(want.read_z), want.read_color);
                        $display("  got st=%0d cnt=%0d pos=%0d x=%0d y=%0d z=%0d col=%06h",
                                 response.status, response.vertex_count, response.position,
                                 $signed(response.read_x), $signed(response.read_y),
                                 $signed(response.read_z), response.read_color);
                    end
                end
            end
        end
    end

    // Watchdog: too long with no word taken in either direction
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((rst_n && start && !busy) || (rst_n && done))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("polyline_vertex_table_unit: mismatch");
        $finish;
    end

    initial
    begin
        stim_row_t dir_rows [25];
        int        k;
        int        phase;
        int        idle_pct;
        int        pick;
        int        mode;
        request_t  rq;

        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        mismatch_count = 0;
        exp_wr         = 0;
        exp_rd         = 0;
        tbl_count      = 0;
        for (k = 0; k < TABLE_DEPTH; k++)
        begin
            tbl_x[k]     = '0;
            tbl_y[k]     = '0;
            tbl_z[k]     = '0;
            tbl_color[k] = '0;
        end

        // Directed rows: empty table, extremes, full walk of each command
        dir_rows[0]  = '{mk_req(CMD_READ, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_rsp(ST_BAD_SLOT, 0, 0, 0, 0, 0, 0)};
        dir_rows[1]  = '{mk_req(CMD_DELETE, 0, 0, 0, 0, 0, 65535), 1'b1,
                         mk_rsp(ST_NONE, 0, 0, 0, 0, 0, 0)};
        dir_rows[2]  = '{mk_req(CMD_MOVE, 1, 1, 1, 0, 0, 0), 1'b1,
                         mk_rsp(ST_BAD_SLOT, 0, 0, 0, 0, 0, 0)};
        dir_rows[3]  = '{mk_req(CMD_UNUSED, 5, 5, 5, 24'h777777, 3, 9), 1'b1,
                         mk_rsp(ST_OK, 0, 0, 0, 0, 0, 0)};
        dir_rows[4]  = '{mk_req(CMD_SMART, 32767, 32767, 32767, 24'hFFFFFF, 0, 0), 1'b1,
                         mk_rsp(ST_OK, 1, 0, 32767, 32767, 32767, 24'hFFFFFF)};
        dir_rows[5]  = '{mk_req(CMD_SMART, -32768, -32768, -32768, 0, 511, 65535), 1'b1,
                         mk_rsp(ST_OK, 2, 1, -32768, -32768, -32768, 0)};
        dir_rows[6]  = '{mk_req(CMD_APPEND, 0, 0, 0, 24'h123456, 0, 0), 1'b1,
                         mk_rsp(ST_OK, 3, 2, 0, 0, 0, 24'h123456)};
        dir_rows[7]  = '{mk_req(CMD_INSERT, 100, -100, 5, 24'hABCDEF, 0, 0), 1'b1,
                         mk_rsp(ST_OK, 4, 0, 100, -100, 5, 24'hABCDEF)};
        dir_rows[8]  = '{mk_req(CMD_INSERT, 1, 2, 3, 24'h111111, 5, 0), 1'b1,
                         mk_rsp(ST_BAD_SLOT, 4, 0, 0, 0, 0, 0)};
        dir_rows[9]  = '{mk_req(CMD_INSERT, 7, 7, 7, 24'h010203, 4, 0), 1'b0, '0};
        dir_rows[10] = '{mk_req(CMD_SMART, 1, 1, 1, 24'h555555, 0, 0), 1'b0, '0};
        dir_rows[11] = '{mk_req(CMD_SMART, 50, -50, 3, 24'hAAAAAA, 0, 0), 1'b0, '0};
        dir_rows[12] = '{mk_req(CMD_MOVE, 32767, 32767, 32767, 0, 0, 0), 1'b0, '0};
        dir_rows[13] = '{mk_req(CMD_MOVE, -32768, -32768, -32768, 0, 1, 0), 1'b0, '0};
        dir_rows[14] = '{mk_req(CMD_MOVE, 1, 1, 1, 0, 511, 0), 1'b0, '0};
        dir_rows[15] = '{mk_req(CMD_READ, 0, 0, 0, 0, 256, 0), 1'b0, '0};
        dir_rows[16] = '{mk_req(CMD_READ, 0, 0, 0, 0, 2, 0), 1'b0, '0};
        dir_rows[17] = '{mk_req(CMD_DELETE, 0, 0, 0, 0, 0, 0), 1'b0, '0};
        dir_rows[18] = '{mk_req(CMD_DELETE, 0, 0, 0, 0, 0, 2), 1'b0, '0};
        dir_rows[19] = '{mk_req(CMD_CLEAR, 9, 9, 9, 24'hFFFFFF, 511, 65535), 1'b1,
                         mk_rsp(ST_OK, 0, 0, 0, 0, 0, 0)};
        dir_rows[20] = '{mk_req(CMD_APPEND, 1000, 1000, 1000, 24'h0000FF, 0, 0), 1'b0, '0};
        dir_rows[21] = '{mk_req(CMD_APPEND, -1000, -1000, -1000, 24'hFF0000, 0, 0),
                         1'b0, '0};
        // removing the last vertex leaves nothing to show
        dir_rows[22] = '{mk_req(CMD_DELETE, -1000, -1000, -1000, 0, 0, 1), 1'b0, '0};
        dir_rows[23] = '{mk_req(CMD_DELETE, 1000, 1000, 1000, 0, 0, 65535), 1'b0, '0};
        dir_rows[24] = '{mk_req(CMD_READ, 0, 0, 0, 0, 0, 0), 1'b0, '0};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < 25; k++)
            issue(dir_rows[k].req, dir_rows[k].has_rsp, dir_rows[k].rsp);
        wait_drained();

        // Fill the table to the brim, back to back
        while (tbl_count < TABLE_DEPTH)
        begin
            pick = $urandom_range(9);
            mode = $urandom_range(3);
            rq = random_request();
            rq.coord_x = random_coord(mode);
            rq.coord_y = random_coord(mode);
            rq.coord_z = random_coord(mode);
            if (pick < 5)
                rq.command = CMD_APPEND;
            else if (pick < 8)
            begin
                rq.command = CMD_INSERT;
                rq.slot    = 9'($urandom_range(tbl_count));
            end
            else
                rq.command = CMD_SMART;
            issue(rq, 1'b0, '0);
        end

        // Full table: the full check wins over the slot check
        issue(mk_req(CMD_APPEND, 1, 1, 1, 24'h010101, 0, 0), 1'b0, '0);
        issue(mk_req(CMD_INSERT, 2, 2, 2, 24'h020202, 300, 0), 1'b0, '0);
        issue(mk_req(CMD_SMART, 3, 3, 3, 24'h030303, 0, 0), 1'b0, '0);
        issue(mk_req(CMD_READ, 0, 0, 0, 0, 255, 0), 1'b0, '0);
        issue(mk_req(CMD_READ, 0, 0, 0, 0, 256, 0), 1'b0, '0);
        issue(mk_req(CMD_MOVE, 32767, -32768, 32767, 0, 255, 0), 1'b0, '0);
        issue(mk_req(CMD_DELETE, 0, 0, 0, 0, 0, 65535), 1'b0, '0);
        issue(mk_req(CMD_INSERT, -5, 6, -7, 24'hC0FFEE, 255, 0), 1'b0, '0);
        issue(mk_req(CMD_APPEND, 4, 4, 4, 24'h040404, 0, 0), 1'b0, '0);
        issue(mk_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        wait_drained();

        // Random phases: sender idle 0, 79 and 37 percent of the time
        for (phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 0 : ((phase == 1) ? 79 : 37);
            for (k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                if (idle_pct > 0 && (k % 32) >= 8)
                begin
                    while ($urandom_range(99) < idle_pct)
                    begin
                        @(negedge clk);
                        start <= 1'b0;
                    end
                end
                if ($urandom_range(49) == 0)
                    wait_drained();
                issue(random_request(), 1'b0, '0);
            end
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("polyline_vertex_table_unit: match");
        else
            $display("polyline_vertex_table_unit: mismatch");
        $finish;
    end

endmodule
